>>> rtl/sqs_pkg.sv
// Shared types, codes and constants for the shift queue with sort.
`default_nettype none
package sqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;

  localparam logic [2:0] OP_ENQ   = 3'd0;
  localparam logic [2:0] OP_DEQ   = 3'd1;
  localparam logic [2:0] OP_CLR   = 3'd2;
  localparam logic [2:0] OP_PRINT = 3'd3;
  localparam logic [2:0] OP_SORT  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [1:0]               status;
    logic                     last;
  } out_item_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SORT,
    FSM_FWD,
    FSM_REV
  } fsm_state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_ROTUP,
    CELL_SORT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      wrap;
    logic      parity;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/sqs_cell.sv
// One storage cell of the queue: holds a slot and trades words with its neighbors.
`default_nettype none
module sqs_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  sqs_pkg::cell_ctl_t                ctl,
  input  logic [CW-1:0]                     count,
  input  logic signed [sqs_pkg::WORD_W-1:0] value_in,
  input  logic signed [sqs_pkg::WORD_W-1:0] left_in,
  input  logic signed [sqs_pkg::WORD_W-1:0] right_in,
  input  logic signed [sqs_pkg::WORD_W-1:0] head_in,
  input  logic signed [sqs_pkg::WORD_W-1:0] tail_in,
  output logic signed [sqs_pkg::WORD_W-1:0] data_out
);
  import sqs_pkg::*;

  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);
  localparam logic          IS_ODD   = 1'(IDX % 2);

  logic signed [WORD_W-1:0] data_r;
  logic signed [WORD_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.cmd)
      CELL_LOAD: begin
        if (count == MY_IDX) begin
          data_nxt = value_in;
        end
      end
      CELL_SHIFT: begin
        // On a rotation the tail slot takes the head word.
        if (ctl.wrap && (NEXT_IDX == count)) begin
          data_nxt = head_in;
        end else begin
          data_nxt = right_in;
        end
      end
      CELL_ROTUP: begin
        if (IDX == 0) begin
          data_nxt = tail_in;
        end else begin
          data_nxt = left_in;
        end
      end
      CELL_SORT: begin
        // Odd-even transposition: the lower cell of a pair keeps the minimum.
        if (ctl.parity == IS_ODD) begin
          if ((NEXT_IDX < count) && (right_in < data_r)) begin
            data_nxt = right_in;
          end
        end else begin
          if ((IDX != 0) && (MY_IDX < count) && (data_r < left_in)) begin
            data_nxt = left_in;
          end
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule
`default_nettype wire

>>> rtl/sqs_ctrl.sv
// Sequencer for the queue: decodes items, drives the cell row and registers results.
`default_nettype none
module sqs_ctrl #(
  parameter int DEPTH = sqs_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  sqs_pkg::in_item_t                 in_item,
  output logic                              busy,
  output logic [CW-1:0]                     count,
  output sqs_pkg::cell_ctl_t                cell_ctl,
  input  logic signed [sqs_pkg::WORD_W-1:0] head_in,
  input  logic signed [sqs_pkg::WORD_W-1:0] tail_in,
  output logic                              out_strobe,
  output sqs_pkg::out_item_t                out_item
);
  import sqs_pkg::*;

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);

  fsm_state_t      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic            out_strobe_r, out_strobe_nxt;
  out_item_t       out_item_r, out_item_nxt;
  logic            accept;
  logic            k_last;
  logic            is_empty;
  logic            is_full;

  assign accept   = start && (state_r == FSM_IDLE);
  assign k_last   = (k_r == (count_r - ONE));
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == FULL_CNT);

  // Next state, count and step counter.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    case (state_r)
      FSM_IDLE: begin
        k_nxt = '0;
        if (accept) begin
          case (in_item.op)
            OP_ENQ: begin
              if (!is_full) begin
                count_nxt = count_r + ONE;
              end
            end
            OP_DEQ: begin
              if (!is_empty) begin
                count_nxt = count_r - ONE;
              end
            end
            OP_CLR: begin
              count_nxt = '0;
            end
            OP_PRINT: begin
              if (!is_empty) begin
                state_nxt = FSM_FWD;
              end
            end
            OP_SORT: begin
              if (!is_empty) begin
                state_nxt = FSM_SORT;
              end
            end
            default: begin
              state_nxt = FSM_IDLE;
            end
          endcase
        end
      end
      FSM_SORT: begin
        k_nxt = k_r + ONE;
        if (k_last) begin
          state_nxt = FSM_REV;
          k_nxt     = '0;
        end
      end
      FSM_FWD, FSM_REV: begin
        k_nxt = k_r + ONE;
        if (k_last) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // Cell commands and result items.
  always_comb begin
    cell_ctl       = '{cmd: CELL_HOLD, wrap: 1'b0, parity: 1'b0};
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '{word: '0, status: ST_OK, last: 1'b1};
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          case (in_item.op)
            OP_ENQ: begin
              out_strobe_nxt = 1'b1;
              if (is_full) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                cell_ctl.cmd = CELL_LOAD;
              end
            end
            OP_DEQ: begin
              out_strobe_nxt = 1'b1;
              if (is_empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                cell_ctl.cmd      = CELL_SHIFT;
                out_item_nxt.word = head_in;
              end
            end
            OP_CLR: begin
              out_strobe_nxt = 1'b1;
            end
            OP_PRINT, OP_SORT: begin
              if (is_empty) begin
                out_strobe_nxt      = 1'b1;
                out_item_nxt.status = ST_EMPTY;
              end
            end
            default: begin
              out_strobe_nxt = 1'b0;
            end
          endcase
        end
      end
      FSM_SORT: begin
        cell_ctl.cmd    = CELL_SORT;
        cell_ctl.parity = k_r[0];
      end
      FSM_FWD: begin
        cell_ctl.cmd      = CELL_SHIFT;
        cell_ctl.wrap     = 1'b1;
        out_strobe_nxt    = 1'b1;
        out_item_nxt.word = head_in;
        out_item_nxt.last = k_last;
      end
      FSM_REV: begin
        cell_ctl.cmd      = CELL_ROTUP;
        out_strobe_nxt    = 1'b1;
        out_item_nxt.word = tail_in;
        out_item_nxt.last = k_last;
      end
      default: begin
        out_strobe_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_IDLE;
      count_r      <= '0;
      k_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      k_r          <= k_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != FSM_IDLE);
  assign count      = count_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
`default_nettype wire

>>> rtl/shift_queue_with_sort.sv
// Top level of the shift queue with sort: a row of slot cells and their sequencer.
// Enqueue, dequeue and clear finish at acceptance; the result item follows in the next cycle.
// Print keeps busy high while it rotates the queue once round, one rotation per emitted item.
// Sort first runs odd-even exchange phases, then emits the words from tail to head.
// Results cannot be stalled by the receiver, so busy depends only on the running operation.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
`default_nettype none
module shift_queue_with_sort #(
  parameter int DEPTH = sqs_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sqs_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output sqs_pkg::out_item_t out_item
);
  import sqs_pkg::*;

  // Count needs to hold DEPTH itself; a slot index only DEPTH-1.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  cell_ctl_t                cell_ctl;
  logic [CW-1:0]            count;
  logic [IW-1:0]            tail_idx;
  logic signed [WORD_W-1:0] slot_w  [DEPTH];
  logic signed [WORD_W-1:0] left_w  [DEPTH];
  logic signed [WORD_W-1:0] right_w [DEPTH];
  logic signed [WORD_W-1:0] head_w;
  logic signed [WORD_W-1:0] tail_w;

  // The head is always slot 0. The tail word feeds the descending emission
  // after a sort; it is only used while the queue holds at least one word.
  assign head_w   = slot_w[0];
  assign tail_idx = IW'(count - CW'(1));
  assign tail_w   = slot_w[tail_idx];

  sqs_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .count      (count),
    .cell_ctl   (cell_ctl),
    .head_in    (head_w),
    .tail_in    (tail_w),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // Each cell sees its two neighbors; the ends of the row see zero, which
  // never reaches a slot that is later read.
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_left_end
        assign left_w[gi] = '0;
      end else begin : g_left
        assign left_w[gi] = slot_w[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_right_end
        assign right_w[gi] = '0;
      end else begin : g_right
        assign right_w[gi] = slot_w[gi+1];
      end

      sqs_cell #(
        .CW  (CW),
        .IDX (gi)
      ) u_cell (
        .clk      (clk),
        .ctl      (cell_ctl),
        .count    (count),
        .value_in (in_item.value),
        .left_in  (left_w[gi]),
        .right_in (right_w[gi]),
        .head_in  (head_w),
        .tail_in  (tail_w),
        .data_out (slot_w[gi])
      );
    end
  endgenerate

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the shift queue with sort: random and directed command traffic.
`timescale 1ns / 1ps
module tb_top;
  import sqs_pkg::*;

  localparam int          DEPTH         = DEPTH_DEF;
  localparam int          CMD_TARGET    = 230;
  localparam int          IDLE_PCT      = 21;
  localparam int          STALL_LIMIT   = 2000;
  // The drain allows for a sort of a full queue: its exchange phases and its emission.
  localparam int          DRAIN_CYCLES  = 2 * DEPTH + 8;
  // Op codes above the sort are spare and must be ignored by the block.
  localparam logic [2:0]  OP_SPARE_LO   = OP_SORT + 3'd1;
  localparam logic [2:0]  OP_SPARE_HI   = 3'd7;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  // The checker keeps its own copy of the queue, predicts the result items of
  // every accepted command and compares the block's results against them in order.
  class sort_queue_checker;
    logic signed [WORD_W-1:0] slots [DEPTH];
    int                       fill;
    out_item_t                pending_results [$];
    int                       errors;
    int                       checked;
    int                       full_hits;
    int                       deepest;
    int                       op_hits [8];

    function new();
      fill    = 0;
      errors  = 0;
      checked = 0;
      full_hits = 0;
      deepest = 0;
      foreach (op_hits[k]) op_hits[k] = 0;
    endfunction

    function void push_result(logic signed [WORD_W-1:0] word, logic [1:0] status,
                              logic last);
      out_item_t res;
      res.word   = word;
      res.status = status;
      res.last   = last;
      pending_results.push_back(res);
    endfunction

    // Sorts the stored words into ascending signed order, in place.
    function void sort_slots();
      int                       i;
      int                       j;
      logic signed [WORD_W-1:0] key;
      for (i = 1; i < fill; i++) begin
        key = slots[i];
        j = i - 1;
        while (j >= 0 && slots[j] > key) begin
          slots[j + 1] = slots[j];
          j--;
        end
        slots[j + 1] = key;
      end
    endfunction

    function void note_command(in_item_t cmd);
      int                       i;
      logic signed [WORD_W-1:0] head;
      op_hits[cmd.op]++;
      case (cmd.op)
        OP_ENQ: begin
          if (fill == DEPTH) begin
            full_hits++;
            push_result('0, ST_FULL, 1'b1);
          end else begin
            slots[fill] = cmd.value;
            fill++;
            push_result('0, ST_OK, 1'b1);
          end
        end
        OP_DEQ: begin
          if (fill == 0) begin
            push_result('0, ST_EMPTY, 1'b1);
          end else begin
            head = slots[0];
            for (i = 0; i + 1 < fill; i++) slots[i] = slots[i + 1];
            fill--;
            push_result(head, ST_OK, 1'b1);
          end
        end
        OP_CLR: begin
          fill = 0;
          push_result('0, ST_OK, 1'b1);
        end
        OP_PRINT: begin
          if (fill == 0) begin
            push_result('0, ST_EMPTY, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) push_result(slots[i], ST_OK, i == fill - 1);
          end
        end
        OP_SORT: begin
          if (fill == 0) begin
            push_result('0, ST_EMPTY, 1'b1);
          end else begin
            // The ascending order stays in the queue; emission runs tail to head.
            sort_slots();
            for (i = fill - 1; i >= 0; i--) push_result(slots[i], ST_OK, i == 0);
          end
        end
        default: begin
        end
      endcase
      if (fill > deepest) deepest = fill;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: word %0d status %0d last %0d",
               got.word, got.status, got.last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.word !== want.word) begin
          $error("word: expected %0d, got %0d", want.word, got.word);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_item;

  sort_queue_checker chk = new();

  // Commands that the block acts on; spare op codes are not counted here.
  int cmds_done    = 0;
  int stall_cycles = 0;

  shift_queue_with_sort #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every result is on the ports for exactly one cycle, so it is taken at the
  // rising edge that ends that cycle and checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) chk.check_result(out_item);
  end

  // The watchdog counts cycles in which neither a command nor a result moves.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: no progress for %0d cycles, %0d results outstanding",
               STALL_LIMIT, chk.pending_results.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one command, starting and ending at a falling edge. Random idle
  // cycles come first unless the sender is in its busy stretch, where it keeps
  // start high back to back. The command is held until busy is seen low at a
  // rising edge, which is the edge that accepts it.
  task automatic issue(logic [2:0] op, logic signed [WORD_W-1:0] value);
    in_item_t cmd;
    bit       quiet;
    cmd.op    = op;
    cmd.value = value;
    quiet = (cmds_done >= 90 && cmds_done < 150);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    chk.note_command(cmd);
    if (op <= OP_SORT) cmds_done++;
    @(negedge clk);
  endtask

  // Values lean toward the signed extremes and a narrow band around zero, so
  // that sorts see duplicates and sign boundaries as well as wide random words.
  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2, 3:    return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // The random part is mostly well-formed sequences: fill bursts that often
  // run into a full queue and end in a print or a sort, and drains that run
  // up to two past empty. Single random commands, clears and spare op codes are
  // mixed in as noise.
  task automatic run_random_traffic();
    int n;
    while (cmds_done < CMD_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(1, DEPTH + 2);
          repeat (n) issue(OP_ENQ, pick_value());
          issue($urandom_range(0, 1) ? OP_SORT : OP_PRINT, pick_value());
        end
        3: begin
          n = chk.fill + $urandom_range(0, 2);
          repeat (n) issue(OP_DEQ, pick_value());
        end
        4: issue(OP_CLR, pick_value());
        5: issue(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), pick_value());
        default: issue(3'($urandom_range(OP_ENQ, OP_SORT)), pick_value());
      endcase
    end
  endtask

  initial begin
    // Synchronous reset, held low and then released at a falling edge.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Print, sort and dequeue on the empty queue each report empty first.
    issue(OP_PRINT, '0);
    issue(OP_SORT, '0);
    issue(OP_DEQ, '0);
    // Extremes of the word, stored out of order so the sort has work to do.
    issue(OP_ENQ, WORD_MAX);
    issue(OP_ENQ, WORD_MIN);
    issue(OP_ENQ, '0);
    issue(OP_ENQ, -1);
    issue(OP_ENQ, 1);
    issue(OP_PRINT, '0);
    // The sort emits in descending order; the next print shows that the
    // ascending order was kept in the queue.
    issue(OP_SORT, '0);
    issue(OP_PRINT, '0);
    issue(OP_DEQ, '0);
    // Spare op codes must produce nothing and leave the queue alone.
    issue(OP_SPARE_LO, -1);
    issue(OP_SPARE_LO + 3'd1, WORD_MIN);
    issue(OP_SPARE_HI, WORD_MAX);
    issue(OP_PRINT, '0);
    issue(OP_CLR, '0);
    issue(OP_PRINT, '0);
    // A single entry sorts as one result with last set.
    issue(OP_ENQ, WORD_MIN);
    issue(OP_SORT, '0);
    issue(OP_DEQ, '0);

    run_random_traffic();

    // Stop sending, wait for every predicted result, then give the block time
    // to show any stray result that nobody expects.
    start <= 1'b0;
    while (chk.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d commands (enq %0d, deq %0d, clear %0d, print %0d, sort %0d)",
             cmds_done, chk.op_hits[OP_ENQ], chk.op_hits[OP_DEQ], chk.op_hits[OP_CLR],
             chk.op_hits[OP_PRINT], chk.op_hits[OP_SORT]);
    $display("tb_top: %0d results checked, full queue hit %0d times, deepest fill %0d",
             chk.checked, chk.full_hits, chk.deepest);
    if (chk.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sqs_pkg.sv
rtl/sqs_cell.sv
rtl/sqs_ctrl.sv
rtl/shift_queue_with_sort.sv
verif/tb_top.sv
